// ===== src/stsf_pkg.sv =====
// package for the subarray target sum finder: sizes, status codes, fsm states
// and the command and status bundles between controller and datapath
// no dependencies
package stsf_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_BITS    = $clog2(MAX_LEN);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int SUM_BITS    = VALUE_BITS + IDX_BITS;
    localparam int TARGET_BITS = 26;
    localparam int CMP_BITS    = (SUM_BITS > TARGET_BITS) ? SUM_BITS : TARGET_BITS;

    // field widths of the stream payloads
    localparam int VALUE_FIELD_BITS = 16;
    localparam int STATUS_BITS      = 2;
    localparam int LEFT_BITS        = 11;
    localparam int RIGHT_BITS       = 10;
    localparam int OUT_DATA_BITS    = 24;

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [PADDR_BITS-1:0] ADDR_TARGET = 3'd0;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_FOUND     = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_TOO_LONG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    push;
        logic    pop_rd;
        logic    pop_sub;
        logic    set_match;
        logic    set_lenerr;
        logic    clear;
        logic    load_out;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic full;
        logic pop_needed;
        logic match;
        logic last;
        logic out_free;
        logic match_done;
        logic length_error;
    } dp_stat_t;

endpackage

// ===== src/stsf_datapath.sv =====
// datapath: window store, running sum, pointers, array flags, result register
// depends on stsf_pkg
module stsf_datapath
    import stsf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic [VALUE_FIELD_BITS-1:0]   in_value,
    input  logic                          in_last,
    input  logic [TARGET_BITS-1:0]        target,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [STATUS_BITS-1:0]        out_status,
    output logic [LEFT_BITS-1:0]          out_left,
    output logic [RIGHT_BITS-1:0]         out_right
);

    logic [VALUE_BITS-1:0]  mem [MAX_LEN];
    logic [VALUE_BITS-1:0]  rd_data_reg;

    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [CNT_BITS-1:0]    left_reg, left_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic                   match_done_reg, match_done_next;
    logic                   lenerr_reg, lenerr_next;
    logic                   last_reg, last_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [LEFT_BITS-1:0]   out_left_reg;
    logic [RIGHT_BITS-1:0]  out_right_reg;
    logic [CNT_BITS-1:0]    hi;
    logic [VALUE_BITS-1:0]  in_val;

    assign in_val = in_value[VALUE_BITS-1:0];
    assign hi     = count_reg - CNT_BITS'(1);

    // window store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[count_reg[IDX_BITS-1:0]] <= in_val;
        end
        if (cmd.pop_rd)
        begin
            rd_data_reg <= mem[left_reg[IDX_BITS-1:0]];
        end
    end

    always_comb
    begin
        sum_next        = sum_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        match_done_next = match_done_reg;
        lenerr_next     = lenerr_reg;
        last_next       = last_reg;
        if (cmd.accept)
        begin
            last_next = in_last;
        end
        if (cmd.push)
        begin
            sum_next   = sum_reg + SUM_BITS'(in_val);
            count_next = count_reg + CNT_BITS'(1);
        end
        if (cmd.pop_sub)
        begin
            sum_next  = sum_reg - SUM_BITS'(rd_data_reg);
            left_next = left_reg + CNT_BITS'(1);
        end
        if (cmd.set_match)
        begin
            match_done_next = 1'b1;
        end
        if (cmd.set_lenerr)
        begin
            lenerr_next = 1'b1;
        end
        if (cmd.clear)
        begin
            sum_next        = '0;
            left_next       = '0;
            count_next      = '0;
            match_done_next = 1'b0;
            lenerr_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            left_reg       <= '0;
            count_reg      <= '0;
            match_done_reg <= 1'b0;
            lenerr_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
            match_done_reg <= match_done_next;
            lenerr_reg     <= lenerr_next;
            last_reg       <= last_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == STAT_FOUND)
            begin
                out_left_reg  <= LEFT_BITS'(left_reg);
                out_right_reg <= RIGHT_BITS'(hi);
            end
            else
            begin
                out_left_reg  <= '0;
                out_right_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;

    assign stat.active       = !match_done_reg && !lenerr_reg;
    assign stat.full         = (count_reg == CNT_BITS'(MAX_LEN));
    assign stat.pop_needed   = (CMP_BITS'(sum_reg) > CMP_BITS'(target)) && (left_reg < count_reg);
    assign stat.match        = (CMP_BITS'(sum_reg) == CMP_BITS'(target));
    assign stat.last         = last_reg;
    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.match_done   = match_done_reg;
    assign stat.length_error = lenerr_reg;

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= count_reg)
        else $error("left pointer passed item count");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(match_done_reg && lenerr_reg))
        else $error("match and length error both set");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_pop_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |=> cmd.pop_sub)
        else $error("pop read not followed by subtract");

endmodule

// ===== src/stsf_controller.sv =====
// controller fsm: accepts beats, sequences window pops and result hand-off
// depends on stsf_pkg
module stsf_controller
    import stsf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = STAT_NOT_FOUND;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.active)
                    begin
                        // array already decided, drop beat
                        cmd.clear = in_last;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_lenerr = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.pop_needed)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP;
                end
                else if (stat.match)
                begin
                    cmd.set_match = 1'b1;
                    state_next    = ST_EMIT;
                end
                else if (stat.last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                cmd.pop_sub = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (stat.length_error)
                begin
                    cmd.out_status = STAT_TOO_LONG;
                end
                else if (stat.match_done)
                begin
                    cmd.out_status = STAT_FOUND;
                end
                else
                begin
                    cmd.out_status = STAT_NOT_FOUND;
                end
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = stat.last;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/subarray_target_sum_finder.sv =====
// top level of the subarray target sum finder: configuration register,
// controller and datapath; depends on stsf_pkg, stsf_controller, stsf_datapath
//
//  channel   | dir | handshake                      | content
//  ----------+-----+--------------------------------+------------------------------
//  s_*       | in  | s_tvalid / s_tready            | value in tdata, end of array in tlast
//  m_*       | out | m_tvalid / m_tready            | left/right index in tdata, status in tuser
//  apb       | in  | psel & penable & pwrite        | target_sum at byte address 0
//
// an input beat goes through an accept state and a window check, plus a read and a
// subtract step for each value popped from the window, set by the single read port
// of the window store; a beat that yields a result then moves it to the result register
// beats after a decided array are accepted and dropped without leaving the idle state
// reset clears all control state; the window store needs no clearing
// a stalled result register holds the block in the hand-off state, but one result
// may wait there while the next beat is accepted and worked on
module subarray_target_sum_finder
    import stsf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [VALUE_FIELD_BITS-1:0] s_tdata,   // [15:0] value
    input  logic                        s_tlast,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_DATA_BITS-1:0]    m_tdata,   // [10:0] left_index, [20:11] right_index, zero pad
    output logic [STATUS_BITS-1:0]      m_tuser,   // [1:0] status
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_BITS-1:0]       paddr,
    input  logic [PDATA_BITS-1:0]       pwdata,
    output logic [PDATA_BITS-1:0]       prdata,
    output logic                        pready
);

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic [TARGET_BITS-1:0] target_reg;
    logic [LEFT_BITS-1:0]   out_left;
    logic [RIGHT_BITS-1:0]  out_right;
    logic                   cfg_wr;

    // target register, written on the apb access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_TARGET))
        begin
            target_reg <= pwdata[TARGET_BITS-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TARGET) ? PDATA_BITS'(target_reg) : '0;

    stsf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stsf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_value   (s_tdata),
        .in_last    (s_tlast),
        .target     (target_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_left   (out_left),
        .out_right  (out_right)
    );

    // pack result beat: left index lowest, then right index, zero pad to bytes
    assign m_tdata = {{(OUT_DATA_BITS - LEFT_BITS - RIGHT_BITS){1'b0}}, out_right, out_left};

endmodule
